// ===== rtl/mrpc_pkg.sv =====
// Shared constants, operation codes, command struct and radix helper for the
// mixed-radix position counter. No dependencies.
package mrpc_pkg;

   // Array shape
   localparam int DIMS       = 4;
   localparam int COORD_BITS = 12;
   localparam int RADIX_BITS = COORD_BITS + 1;
   localparam int RADIX_MAX  = 1 << COORD_BITS;
   localparam int DIM_BITS   = (DIMS > 1) ? $clog2(DIMS) : 1;

   // Port field widths
   localparam int OP_BITS        = 3;
   localparam int SEL_BITS       = 2;
   localparam int VAL_BITS       = 12;
   localparam int IDX_BITS       = 48;
   localparam int PRE_BITS       = 3;
   localparam int OUT_DIMS       = 4;
   localparam int OUT_COORD_BITS = 12;
   localparam int CFG_BITS       = 13;
   localparam int CFG_REGS       = 4;
   localparam int CFG_IDX_BITS   = 2;

   // Index arithmetic: 48-bit accumulator split into two halves per multiply
   localparam int HALF_BITS = IDX_BITS / 2;
   localparam int PROD_BITS = HALF_BITS + RADIX_BITS;

   // Linear-index split: quotient bits retired per cycle
   localparam int DIV_BITS_PER_CYCLE = 8;
   localparam int DIV_CHUNKS         = IDX_BITS / DIV_BITS_PER_CYCLE;
   localparam int CHUNK_BITS         = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;

   typedef enum logic [OP_BITS-1:0] {
      OP_INC   = 3'd0,
      OP_DEC   = 3'd1,
      OP_CLEAR = 3'd2,
      OP_LOAD  = 3'd3,
      OP_WRITE = 3'd4,
      OP_READ  = 3'd5
   } op_type;

   typedef struct packed {
      logic                capture;
      logic                update;
      logic                ripple;
      logic                div_step;
      logic                div_last;
      logic                mul;
      logic                add;
      logic                publish;
      logic [DIM_BITS-1:0] dim;
   } cmd_type;

   // Radix zero acts as one; anything above 2^COORD_BITS saturates there.
   function automatic logic [RADIX_BITS-1:0] eff_radix(input logic [CFG_BITS-1:0] raw);
      logic [RADIX_BITS-1:0] r;
      if (raw == '0) begin
         r = RADIX_BITS'(1);
      end else if (32'(raw) > RADIX_MAX) begin
         r = RADIX_BITS'(RADIX_MAX);
      end else begin
         r = RADIX_BITS'(raw);
      end
      return r;
   endfunction

endpackage

// ===== rtl/mixed_radix_position_counter_unit.sv =====
// Clear, write and read take one update step, increment and decrement a carry ripple and
// a linear load a divide pass before the index accumulation. The next transaction can be
// accepted in the same cycle the result is shown. The divider retires 8 quotient bits a
// cycle and the index accumulators do a multiply step and an add step per dimension.
// Synchronous reset: coordinates to zero, every radix to one, both channels idle.
// Top level of the mixed-radix position counter; instantiates mrpc_ctrl and
// mrpc_datapath, uses mrpc_pkg.
module mixed_radix_position_counter_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mrpc_pkg::OP_BITS-1:0]          req_operation,
   input  logic [mrpc_pkg::SEL_BITS-1:0]         req_dim_select,
   input  logic [mrpc_pkg::VAL_BITS-1:0]         req_coord_value,
   input  logic [mrpc_pkg::IDX_BITS-1:0]         req_linear_value,
   input  logic [mrpc_pkg::PRE_BITS-1:0]         req_prefix_count,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mrpc_pkg::OUT_COORD_BITS-1:0]   rsp_coord_out0,
   output logic [mrpc_pkg::OUT_COORD_BITS-1:0]   rsp_coord_out1,
   output logic [mrpc_pkg::OUT_COORD_BITS-1:0]   rsp_coord_out2,
   output logic [mrpc_pkg::OUT_COORD_BITS-1:0]   rsp_coord_out3,
   output logic [mrpc_pkg::IDX_BITS-1:0]         rsp_linear_index,
   output logic [mrpc_pkg::IDX_BITS-1:0]         rsp_super_index,
   output logic [mrpc_pkg::OUT_DIMS-1:0]         rsp_at_last_mask,
   // radix registers
   input  logic                                  csr_wr_en,
   input  logic [mrpc_pkg::CFG_IDX_BITS-1:0]     csr_index,
   input  logic [mrpc_pkg::CFG_BITS-1:0]         csr_wr_data
);
   import mrpc_pkg::*;

   // Command bundle from the sequencer; dim selects the dimension being worked
   cmd_type cmd;

   // The sequencer owns both handshakes. A transaction is taken in idle,
   // then walks: an update step or a ripple / divide pass over the
   // dimensions, then a multiply-add pass that rebuilds both indexes.
   mrpc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd)
   );

   // Coordinates, radices, divider and index accumulators. The result
   // registers load only when the response slot is free, so a stalled
   // response holds its payload.
   mrpc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_operation    (req_operation),
      .req_dim_select   (req_dim_select),
      .req_coord_value  (req_coord_value),
      .req_linear_value (req_linear_value),
      .req_prefix_count (req_prefix_count),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .rsp_coord_out0   (rsp_coord_out0),
      .rsp_coord_out1   (rsp_coord_out1),
      .rsp_coord_out2   (rsp_coord_out2),
      .rsp_coord_out3   (rsp_coord_out3),
      .rsp_linear_index (rsp_linear_index),
      .rsp_super_index  (rsp_super_index),
      .rsp_at_last_mask (rsp_at_last_mask)
   );

endmodule

// ===== rtl/mrpc_ctrl.sv =====
// Sequencer for the mixed-radix position counter: walks dimensions for
// carry ripple, radix division and index accumulation. Uses mrpc_pkg.
module mrpc_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [mrpc_pkg::OP_BITS-1:0]   req_operation,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mrpc_pkg::cmd_type              cmd
);
   import mrpc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_RIPPLE,
      S_DIVIDE,
      S_MUL,
      S_ADD,
      S_PUBLISH
   } state_type;

   localparam logic [DIM_BITS-1:0]   DIM_LAST   = DIM_BITS'(DIMS - 1);
   localparam logic [CHUNK_BITS-1:0] CHUNK_LAST = CHUNK_BITS'(DIV_CHUNKS - 1);

   state_type             state_ff, state_in;
   logic [DIM_BITS-1:0]   dim_ff, dim_in;
   logic [CHUNK_BITS-1:0] chunk_ff, chunk_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      dim_in       = dim_ff;
      chunk_in     = chunk_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.dim      = dim_ff;

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_operation)
                  OP_INC, OP_DEC: begin
                     state_in = S_RIPPLE;
                     dim_in   = DIM_LAST;
                  end
                  OP_LOAD: begin
                     state_in = S_DIVIDE;
                     dim_in   = DIM_LAST;
                     chunk_in = '0;
                  end
                  default: begin
                     state_in = S_UPDATE;
                  end
               endcase
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_MUL;
            dim_in     = '0;
         end
         S_RIPPLE: begin
            cmd.ripple = 1'b1;
            if (dim_ff == '0) begin
               state_in = S_MUL;
            end else begin
               dim_in = dim_ff - 1'b1;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            cmd.div_last = (chunk_ff == CHUNK_LAST);
            if (chunk_ff == CHUNK_LAST) begin
               chunk_in = '0;
               if (dim_ff == '0) begin
                  state_in = S_MUL;
               end else begin
                  dim_in = dim_ff - 1'b1;
               end
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add = 1'b1;
            if (dim_ff == DIM_LAST) begin
               state_in = S_PUBLISH;
            end else begin
               dim_in   = dim_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_PUBLISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dim_ff       <= '0;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dim_ff       <= dim_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/mrpc_datapath.sv =====
// Datapath of the mixed-radix position counter: coordinates, radix registers,
// 8-bit-per-cycle divider, split-multiply index accumulators, result registers.
// Uses mrpc_pkg; driven by mrpc_ctrl commands.
module mrpc_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mrpc_pkg::cmd_type                     cmd,
   input  logic [mrpc_pkg::OP_BITS-1:0]          req_operation,
   input  logic [mrpc_pkg::SEL_BITS-1:0]         req_dim_select,
   input  logic [mrpc_pkg::VAL_BITS-1:0]         req_coord_value,
   input  logic [mrpc_pkg::IDX_BITS-1:0]         req_linear_value,
   input  logic [mrpc_pkg::PRE_BITS-1:0]         req_prefix_count,
   input  logic                                  csr_wr_en,
   input  logic [mrpc_pkg::CFG_IDX_BITS-1:0]     csr_index,
   input  logic [mrpc_pkg::CFG_BITS-1:0]         csr_wr_data,
   output logic [mrpc_pkg::OUT_COORD_BITS-1:0]   rsp_coord_out0,
   output logic [mrpc_pkg::OUT_COORD_BITS-1:0]   rsp_coord_out1,
   output logic [mrpc_pkg::OUT_COORD_BITS-1:0]   rsp_coord_out2,
   output logic [mrpc_pkg::OUT_COORD_BITS-1:0]   rsp_coord_out3,
   output logic [mrpc_pkg::IDX_BITS-1:0]         rsp_linear_index,
   output logic [mrpc_pkg::IDX_BITS-1:0]         rsp_super_index,
   output logic [mrpc_pkg::OUT_DIMS-1:0]         rsp_at_last_mask
);
   import mrpc_pkg::*;

   // State and configuration
   logic [COORD_BITS-1:0] coord_ff [DIMS];
   logic [COORD_BITS-1:0] coord_in [DIMS];
   logic [CFG_BITS-1:0]   radix_ff [DIMS];

   // Captured transaction
   logic [OP_BITS-1:0]  op_ff;
   logic [SEL_BITS-1:0] sel_ff;
   logic [VAL_BITS-1:0] val_ff;
   logic [PRE_BITS-1:0] pre_ff;

   // Sequencing registers
   logic                  carry_ff, carry_in;
   logic [IDX_BITS-1:0]   quo_ff;
   logic [COORD_BITS-1:0] rem_ff;
   logic [IDX_BITS-1:0]   acc_lin_ff, acc_sup_ff;
   logic [PROD_BITS-1:0]  plo_lin_ff, plo_sup_ff;
   logic [HALF_BITS-1:0]  phi_lin_ff, phi_sup_ff;

   // Result registers
   logic [OUT_COORD_BITS-1:0] out_coord_ff [OUT_DIMS];
   logic [OUT_DIMS-1:0]       out_mask_ff;
   logic [IDX_BITS-1:0]       out_lin_ff, out_sup_ff;

   // Current-dimension view
   logic [COORD_BITS-1:0] cur_coord;
   logic [RADIX_BITS-1:0] cur_radix;
   logic [RADIX_BITS-1:0] inc_sum;
   logic [COORD_BITS-1:0] step_coord;

   // Divider chunk
   logic [COORD_BITS-1:0] div_rem;
   logic [IDX_BITS-1:0]   div_quo;
   logic [RADIX_BITS-1:0] div_trial;

   // Write clamp, per dimension
   logic [COORD_BITS-1:0] wr_lim [DIMS];

   // Multiplier and adder terms
   logic [PROD_BITS-1:0]  plo_lin, plo_sup, phi_lin_full, phi_sup_full;
   logic [IDX_BITS-1:0]   coord_term, sup_term;

   // Result formatting
   logic [OUT_COORD_BITS-1:0] pad_coord [OUT_DIMS];
   logic [OUT_DIMS-1:0]       pad_mask;

   assign cur_coord = coord_ff[cmd.dim];
   assign cur_radix = eff_radix(radix_ff[cmd.dim]);
   assign inc_sum   = {1'b0, cur_coord} + 1'b1;

   // Carry or borrow step on the current dimension
   always_comb begin
      carry_in   = carry_ff;
      step_coord = cur_coord;
      if (carry_ff) begin
         if (op_ff == OP_INC) begin
            carry_in   = (inc_sum >= cur_radix);
            step_coord = (inc_sum >= cur_radix) ? '0 : inc_sum[COORD_BITS-1:0];
         end else begin
            carry_in   = (cur_coord == '0);
            step_coord = (cur_coord == '0) ? COORD_BITS'(cur_radix - 1'b1)
                                           : cur_coord - 1'b1;
         end
      end
   end

   // Restoring division, DIV_BITS_PER_CYCLE quotient bits per cycle
   always_comb begin
      div_rem   = rem_ff;
      div_quo   = quo_ff;
      div_trial = '0;
      for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
         div_trial = {div_rem, div_quo[IDX_BITS-1]};
         div_quo   = {div_quo[IDX_BITS-2:0], 1'b0};
         if (div_trial >= cur_radix) begin
            div_rem    = COORD_BITS'(div_trial - cur_radix);
            div_quo[0] = 1'b1;
         end else begin
            div_rem = div_trial[COORD_BITS-1:0];
         end
      end
   end

   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         wr_lim[d] = COORD_BITS'(eff_radix(radix_ff[d]) - 1'b1);
      end
   end

   // Next coordinates
   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         coord_in[d] = coord_ff[d];
         if (cmd.update) begin
            if (op_ff == OP_CLEAR) begin
               coord_in[d] = '0;
            end else if (op_ff == OP_WRITE && 32'(sel_ff) == d) begin
               coord_in[d] = (32'(val_ff) > 32'(wr_lim[d])) ? wr_lim[d]
                                                            : COORD_BITS'(val_ff);
            end
         end
         if (cmd.ripple && 32'(cmd.dim) == d) begin
            coord_in[d] = step_coord;
         end
         if (cmd.div_last && 32'(cmd.dim) == d) begin
            coord_in[d] = div_rem;
         end
      end
   end

   // Horner step: acc * radix split into two half-width products
   assign plo_lin      = PROD_BITS'(acc_lin_ff[HALF_BITS-1:0]) * PROD_BITS'(cur_radix);
   assign plo_sup      = PROD_BITS'(acc_sup_ff[HALF_BITS-1:0]) * PROD_BITS'(cur_radix);
   assign phi_lin_full = PROD_BITS'(acc_lin_ff[IDX_BITS-1:HALF_BITS]) * PROD_BITS'(cur_radix);
   assign phi_sup_full = PROD_BITS'(acc_sup_ff[IDX_BITS-1:HALF_BITS]) * PROD_BITS'(cur_radix);
   assign coord_term   = IDX_BITS'(cur_coord);
   assign sup_term     = (32'(pre_ff) > 32'(cmd.dim)) ? coord_term : '0;

   // Result formatting; absent dimensions read as zero
   always_comb begin
      for (int k = 0; k < OUT_DIMS; k++) begin
         pad_coord[k] = '0;
         pad_mask[k]  = 1'b0;
      end
      for (int d = 0; d < DIMS; d++) begin
         if (d < OUT_DIMS) begin
            pad_coord[d] = OUT_COORD_BITS'(coord_ff[d]);
            pad_mask[d]  = ({1'b0, coord_ff[d]} == eff_radix(radix_ff[d]) - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < DIMS; d++) begin
            coord_ff[d] <= '0;
            radix_ff[d] <= CFG_BITS'(1);
         end
      end else begin
         for (int d = 0; d < DIMS; d++) begin
            coord_ff[d] <= coord_in[d];
            if (csr_wr_en && 32'(csr_index) == d && d < CFG_REGS) begin
               radix_ff[d] <= csr_wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_operation;
         sel_ff     <= req_dim_select;
         val_ff     <= req_coord_value;
         pre_ff     <= req_prefix_count;
         quo_ff     <= req_linear_value;
         rem_ff     <= '0;
         carry_ff   <= 1'b1;
         acc_lin_ff <= '0;
         acc_sup_ff <= '0;
      end else begin
         if (cmd.ripple) begin
            carry_ff <= carry_in;
         end
         if (cmd.div_step) begin
            quo_ff <= div_quo;
            rem_ff <= cmd.div_last ? '0 : div_rem;
         end
         if (cmd.mul) begin
            plo_lin_ff <= plo_lin;
            plo_sup_ff <= plo_sup;
            phi_lin_ff <= phi_lin_full[HALF_BITS-1:0];
            phi_sup_ff <= phi_sup_full[HALF_BITS-1:0];
         end
         if (cmd.add) begin
            acc_lin_ff <= IDX_BITS'(plo_lin_ff) + {phi_lin_ff, HALF_BITS'(0)} + coord_term;
            acc_sup_ff <= IDX_BITS'(plo_sup_ff) + {phi_sup_ff, HALF_BITS'(0)} + sup_term;
         end
      end
      if (cmd.publish) begin
         for (int k = 0; k < OUT_DIMS; k++) begin
            out_coord_ff[k] <= pad_coord[k];
         end
         out_mask_ff <= pad_mask;
         out_lin_ff  <= acc_lin_ff;
         out_sup_ff  <= acc_sup_ff;
      end
   end

   assign rsp_coord_out0   = out_coord_ff[0];
   assign rsp_coord_out1   = out_coord_ff[1];
   assign rsp_coord_out2   = out_coord_ff[2];
   assign rsp_coord_out3   = out_coord_ff[3];
   assign rsp_linear_index = out_lin_ff;
   assign rsp_super_index  = out_sup_ff;
   assign rsp_at_last_mask = out_mask_ff;

endmodule

// ===== rtl/mrpc_checker.sv =====
// Port-level checks for the mixed-radix position counter, bound to the top
// level. Uses only the top-level ports.
module mrpc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [mrpc_pkg::IDX_BITS-1:0]       rsp_linear_index,
   input logic [mrpc_pkg::IDX_BITS-1:0]       rsp_super_index
);

   // a taken transaction makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side not stalled after a transaction was taken");

   // leaving busy means a result was just posted; the stall also drops as reset releases
   assert property (@(posedge clock) disable iff (reset)
      ($fell(req_stall) && !$past(reset)) |-> rsp_valid)
      else $error("block went idle without posting a result");

   // a fresh result appears only as the block finishes its transaction
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $fell(req_stall))
      else $error("result posted while no transaction was finishing");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_linear_index) && $stable(rsp_super_index)))
      else $error("stalled result changed or dropped");

endmodule

bind mixed_radix_position_counter_unit mrpc_checker u_mrpc_checker (.*);

// ===== dv/mixed_radix_position_counter_unit_tb.sv =====
// Self-checking testbench for mixed_radix_position_counter_unit: directed and random
// transactions, radix reprogramming between phases, result checking via a scoreboard.
// Depends on rtl/mrpc_pkg.sv and rtl/mixed_radix_position_counter_unit.sv.
module mixed_radix_position_counter_unit_tb;
   import mrpc_pkg::*;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 40;
   localparam logic [63:0] IDX_MASK = (64'd1 << IDX_BITS) - 64'd1;
   localparam logic [CFG_BITS-1:0] RADIX_TOP = CFG_BITS'(RADIX_MAX);

   // Operation codes outside the named set; the block treats them as a read.
   localparam logic [OP_BITS-1:0] OP_RESERVED_LO = 3'd6;
   localparam logic [OP_BITS-1:0] OP_RESERVED_HI = 3'd7;

   typedef enum logic [CFG_IDX_BITS-1:0] {
      RADIX_DIM0 = 2'd0,
      RADIX_DIM1 = 2'd1,
      RADIX_DIM2 = 2'd2,
      RADIX_DIM3 = 2'd3
   } radix_reg_e;

   typedef struct packed {
      logic [OUT_DIMS-1:0][OUT_COORD_BITS-1:0] coord;
      logic [IDX_BITS-1:0]                     linear;
      logic [IDX_BITS-1:0]                     super_idx;
      logic [OUT_DIMS-1:0]                     last_mask;
   } position_t;

   // Tracks the counter position and radices; queues the position each transaction
   // should report and compares it against what comes out.
   class position_scoreboard;
      logic [COORD_BITS-1:0] coord [DIMS];
      logic [CFG_BITS-1:0]   radix_raw [DIMS];
      position_t             awaited [$];
      int                    errors;

      function new();
         foreach (coord[d]) begin
            coord[d]     = '0;
            radix_raw[d] = CFG_BITS'(1);
         end
         errors = 0;
      endfunction

      function void set_radix(int d, logic [CFG_BITS-1:0] value);
         radix_raw[d] = value;
      endfunction

      // Radix zero counts as one; anything past the coordinate range saturates.
      function int unsigned span(int d);
         if (radix_raw[d] == 0) return 1;
         if (radix_raw[d] > RADIX_MAX) return RADIX_MAX;
         return radix_raw[d];
      endfunction

      // Row-major index over the leading keep dimensions, modulo 2^48.
      function logic [IDX_BITS-1:0] flat_index(int keep);
         logic [63:0] acc;
         acc = '0;
         for (int d = 0; d < DIMS; d++) begin
            acc = (acc * span(d)) & IDX_MASK;
            if (d < keep) acc = (acc + coord[d]) & IDX_MASK;
         end
         return acc[IDX_BITS-1:0];
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_request(logic [OP_BITS-1:0] op, logic [SEL_BITS-1:0] sel,
                                 logic [VAL_BITS-1:0] value, logic [IDX_BITS-1:0] lin,
                                 logic [PRE_BITS-1:0] keep);
         logic        carry;
         logic [63:0] rest;
         int unsigned lim;
         position_t   want;
         carry = 1'b1;
         rest  = 64'(lin);
         case (op)
            OP_INC: begin
               for (int d = DIMS - 1; d >= 0; d--) begin
                  if (carry) begin
                     if (coord[d] + 1 >= span(d)) begin
                        coord[d] = '0;
                     end else begin
                        coord[d] = coord[d] + 1'b1;
                        carry    = 1'b0;
                     end
                  end
               end
            end
            OP_DEC: begin
               for (int d = DIMS - 1; d >= 0; d--) begin
                  if (carry) begin
                     if (coord[d] == 0) begin
                        coord[d] = COORD_BITS'(span(d) - 1);
                     end else begin
                        coord[d] = coord[d] - 1'b1;
                        carry    = 1'b0;
                     end
                  end
               end
            end
            OP_CLEAR: begin
               foreach (coord[d]) coord[d] = '0;
            end
            OP_LOAD: begin
               for (int d = DIMS - 1; d >= 0; d--) begin
                  coord[d] = COORD_BITS'(rest % span(d));
                  rest     = rest / span(d);
               end
            end
            OP_WRITE: begin
               if (sel < DIMS) begin
                  lim        = span(sel) - 1;
                  coord[sel] = (value > lim) ? COORD_BITS'(lim) : COORD_BITS'(value);
               end
            end
            default: begin
            end
         endcase
         want = '0;
         for (int d = 0; d < DIMS; d++) begin
            want.coord[d]     = OUT_COORD_BITS'(coord[d]);
            want.last_mask[d] = (coord[d] == span(d) - 1);
         end
         want.linear    = flat_index(DIMS);
         want.super_idx = flat_index(keep);
         awaited.push_back(want);
      endfunction

      function void compare_field(string name, logic [IDX_BITS-1:0] want,
                                  logic [IDX_BITS-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(position_t got);
         position_t want;
         if (awaited.size() == 0) begin
            $display("%0t: result with no transaction outstanding: linear_index 0x%0h",
                     $time, got.linear);
            errors++;
            return;
         end
         want = awaited.pop_front();
         for (int d = 0; d < OUT_DIMS; d++)
            compare_field($sformatf("coord_out%0d", d), want.coord[d], got.coord[d]);
         compare_field("linear_index", want.linear, got.linear);
         compare_field("super_index", want.super_idx, got.super_idx);
         compare_field("at_last_mask", want.last_mask, got.last_mask);
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [OP_BITS-1:0]        req_operation;
   logic [SEL_BITS-1:0]       req_dim_select;
   logic [VAL_BITS-1:0]       req_coord_value;
   logic [IDX_BITS-1:0]       req_linear_value;
   logic [PRE_BITS-1:0]       req_prefix_count;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [OUT_COORD_BITS-1:0] rsp_coord_out0;
   logic [OUT_COORD_BITS-1:0] rsp_coord_out1;
   logic [OUT_COORD_BITS-1:0] rsp_coord_out2;
   logic [OUT_COORD_BITS-1:0] rsp_coord_out3;
   logic [IDX_BITS-1:0]       rsp_linear_index;
   logic [IDX_BITS-1:0]       rsp_super_index;
   logic [OUT_DIMS-1:0]       rsp_at_last_mask;
   logic                      csr_wr_en;
   logic [CFG_IDX_BITS-1:0]   csr_index;
   logic [CFG_BITS-1:0]       csr_wr_data;

   position_scoreboard sb = new();
   bit                 idle_enabled = 1'b1;
   int                 cycle_count = 0;

   mixed_radix_position_counter_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_dim_select   (req_dim_select),
      .req_coord_value  (req_coord_value),
      .req_linear_value (req_linear_value),
      .req_prefix_count (req_prefix_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coord_out0   (rsp_coord_out0),
      .rsp_coord_out1   (rsp_coord_out1),
      .rsp_coord_out2   (rsp_coord_out2),
      .rsp_coord_out3   (rsp_coord_out3),
      .rsp_linear_index (rsp_linear_index),
      .rsp_super_index  (rsp_super_index),
      .rsp_at_last_mask (rsp_at_last_mask),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, sb.pending());
         $display("Some tests failed");
         $finish;
      end
   end

   // Check every result transaction against the oldest queued position.
   always @(posedge clock) begin : result_monitor
      position_t seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.coord[0]  = rsp_coord_out0;
         seen.coord[1]  = rsp_coord_out1;
         seen.coord[2]  = rsp_coord_out2;
         seen.coord[3]  = rsp_coord_out3;
         seen.linear    = rsp_linear_index;
         seen.super_idx = rsp_super_index;
         seen.last_mask = rsp_at_last_mask;
         sb.check_result(seen);
      end
   end

   // Backpressure the result channel in random bursts; drop it once idling is off.
   initial begin : result_stall_gen
      int   n;
      logic level;
      rsp_stall = 1'b0;
      forever begin
         level = ($urandom_range(0, 1) == 1);
         n     = level ? $urandom_range(1, 16) : $urandom_range(1, 24);
         repeat (n) begin
            @(negedge clock);
            rsp_stall = idle_enabled ? level : 1'b0;
         end
      end
   end

   // Present one request transaction and hold it until the block takes it.
   task automatic send_item(logic [OP_BITS-1:0] op, logic [SEL_BITS-1:0] sel,
                            logic [VAL_BITS-1:0] value, logic [IDX_BITS-1:0] lin,
                            logic [PRE_BITS-1:0] keep);
      @(negedge clock);
      req_valid        = 1'b1;
      req_operation    = op;
      req_dim_select   = sel;
      req_coord_value  = value;
      req_linear_value = lin;
      req_prefix_count = keep;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, sel, value, lin, keep);
   endtask

   // Insert a random gap on the request side now and then.
   task automatic maybe_pause();
      int n;
      if (!idle_enabled || $urandom_range(0, 2) != 0) return;
      n = $urandom_range(1, 16);
      repeat (n) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   // Drop valid and hold until every queued result has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Reprogram all radices with the block idle.
   task automatic program_radices(logic [CFG_BITS-1:0] r0, logic [CFG_BITS-1:0] r1,
                                  logic [CFG_BITS-1:0] r2, logic [CFG_BITS-1:0] r3);
      logic [CFG_BITS-1:0] value [4];
      value = '{r0, r1, r2, r3};
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_wr_en   = 1'b1;
         csr_index   = radix_reg_e'(i);
         csr_wr_data = value[i];
         sb.set_radix(i, value[i]);
      end
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [IDX_BITS-1:0] random_index();
      logic [31:0] hi;
      logic [31:0] lo;
      hi = $urandom();
      lo = $urandom();
      return {hi[IDX_BITS-33:0], lo};
   endfunction

   // Bias toward small radices so carries and borrows ripple often.
   function automatic logic [CFG_BITS-1:0] pick_radix();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CFG_BITS'(1);
         2, 3, 4: return CFG_BITS'($urandom_range(2, 6));
         5, 6:    return CFG_BITS'($urandom_range(7, 64));
         7:       return RADIX_TOP;
         8:       return CFG_BITS'($urandom_range(RADIX_MAX + 1, (1 << CFG_BITS) - 1));
         default: return CFG_BITS'($urandom_range(1, RADIX_MAX));
      endcase
   endfunction

   task automatic send_random_item();
      int                  pick;
      logic [OP_BITS-1:0]  op;
      logic [VAL_BITS-1:0] value;
      logic [IDX_BITS-1:0] lin;
      pick = $urandom_range(0, 99);
      if (pick < 30)      op = OP_INC;
      else if (pick < 50) op = OP_DEC;
      else if (pick < 54) op = OP_CLEAR;
      else if (pick < 68) op = OP_LOAD;
      else if (pick < 84) op = OP_WRITE;
      else if (pick < 94) op = OP_READ;
      else if (pick < 97) op = OP_RESERVED_LO;
      else                op = OP_RESERVED_HI;
      value = $urandom_range(0, 1) ? VAL_BITS'($urandom_range(0, 4095))
                                   : VAL_BITS'($urandom_range(0, 7));
      lin   = $urandom_range(0, 1) ? random_index() : IDX_BITS'($urandom_range(0, 5000));
      maybe_pause();
      send_item(op, SEL_BITS'($urandom_range(0, 3)), value, lin,
                PRE_BITS'($urandom_range(0, 7)));
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_READ;
      req_dim_select   = '0;
      req_coord_value  = '0;
      req_linear_value = '0;
      req_prefix_count = '0;
      csr_wr_en        = 1'b0;
      csr_index        = RADIX_DIM0;
      csr_wr_data      = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Reset radices are all one: every coordinate sits at its last value.
      send_item(OP_READ, 0, 0, '0, 0);
      send_item(OP_INC, 3, 4095, '1, 7);

      // Radix zero on dim1, an oversized radix on dim3.
      program_radices(3, 0, 5, '1);
      send_item(OP_READ, 0, 0, '0, 0);
      send_item(OP_DEC, 0, 0, '0, 7);             // borrow wraps every dimension
      send_item(OP_INC, 0, 0, '0, 4);             // and the carry wraps back to zero
      send_item(OP_WRITE, 3, 4095, '0, 6);        // top of a saturated radix
      send_item(OP_INC, 0, 0, '0, 5);             // ripple into dim2
      send_item(OP_WRITE, 2, 4095, '0, 3);        // clamp to radix minus one
      send_item(OP_WRITE, 1, 7, '0, 2);           // disabled dimension clamps to zero
      send_item(OP_WRITE, 0, 2, '0, 1);
      send_item(OP_LOAD, 0, 0, '1, 4);            // excess above the product dropped
      send_item(OP_LOAD, 0, 0, '0, 0);
      send_item(OP_LOAD, 1, 1234, 48'd12345, 2);
      send_item(OP_CLEAR, 2, 4095, '1, 7);
      send_item(OP_RESERVED_LO, 3, 4095, 48'hAAAA_AAAA_AAAA, 3);
      send_item(OP_RESERVED_HI, 1, 0, 48'h5555_5555_5555, 5);
      send_item(OP_WRITE, 3, 4000, '0, 4);        // park dim3 high before shrinking it

      // Shrink dim3 under its coordinate: no flag, decrement subtracts, increment wraps.
      program_radices(RADIX_TOP, RADIX_TOP, RADIX_TOP, 2);
      send_item(OP_READ, 0, 0, '0, 4);
      send_item(OP_DEC, 0, 0, '0, 6);
      send_item(OP_INC, 0, 0, '0, 2);
      send_item(OP_LOAD, 0, 0, '1, 7);
      send_item(OP_INC, 0, 0, '0, 1);
      send_item(OP_DEC, 0, 0, '0, 0);

      // Random phases: tiny radices first, full-size radices last with no idling.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            program_radices(2, 2, 2, 2);
         end else if (phase == PHASES - 1) begin
            program_radices(RADIX_TOP, RADIX_TOP, RADIX_TOP, RADIX_TOP);
            idle_enabled = 1'b0;
         end else begin
            program_radices(pick_radix(), pick_radix(), pick_radix(), pick_radix());
         end
         repeat (ITEMS_PER_PHASE) send_random_item();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
